// ----- rtl/cpbd_pkg.sv -----
// types and constants shared by the cassette pulse byte decoder
`timescale 1ns / 1ps

package cpbd_pkg;

  localparam int TICK_W = 24;

  typedef struct packed {
    logic [1:0]        port_bits;
    logic [TICK_W-1:0] elapsed_ticks;
  } write_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       stream_end;
  } result_item_t;

  typedef enum logic {
    CFG_ONE_BIT_WINDOW = 1'b0,
    CFG_OVERRUN_WINDOW = 1'b1
  } cfg_index_t;

  localparam logic [TICK_W-1:0] ONE_BIT_WINDOW_RESET = 24'd480000;
  localparam logic [TICK_W-1:0] OVERRUN_WINDOW_RESET = 24'd1600000;

  localparam logic [1:0]  PULSE_BITS     = 2'b01;
  localparam logic [15:0] SYNC_SILENCE   = 16'hAAAA;
  localparam logic [15:0] SYNC_MARK      = 16'hEEBB;
  localparam logic [7:0]  SYNC_BYTE      = 8'hA5;
  localparam logic [4:0]  BYTE_BITS_DONE = 5'd17;
  localparam logic [4:0]  BYTE_BITS_FULL = 5'd16;
  localparam logic [3:0]  OPEN_COUNT     = 4'd9;

endpackage

// ----- rtl/cpbd_core.sv -----
// decoder state and the single-pass update for one port write
`timescale 1ns / 1ps

module cpbd_core
  import cpbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  write_item_t       item,
  input  logic [TICK_W-1:0] one_bit_window,
  input  logic [TICK_W-1:0] overrun_window,
  output result_item_t      result
);

  typedef enum logic [1:0] {
    HUNT_SILENCE = 2'd0,
    HUNT_SYNC    = 2'd1,
    IN_DATA      = 2'd2
  } phase_t;

  logic [15:0] pulse_shift, pulse_shift_next;
  phase_t      sync_phase, sync_phase_next;
  logic [4:0]  bit_tally, bit_tally_next;
  logic [3:0]  bytes_seen, bytes_seen_next;

  function automatic logic [7:0] gather_even(input logic [15:0] sh);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      v[i] = sh[2*i];
    end
    return v;
  endfunction

  function automatic logic [3:0] count_up(input logic [3:0] n);
    return (n < OPEN_COUNT) ? 4'(n + 4'd1) : n;
  endfunction

  always_comb begin
    logic [15:0] ps;
    phase_t      ph;
    logic [4:0]  tl;
    logic [3:0]  bs;
    logic [4:0]  gap;
    ps  = pulse_shift;
    ph  = sync_phase;
    tl  = bit_tally;
    bs  = bytes_seen;
    gap = '0;
    result = '0;
    if (item.elapsed_ticks >= overrun_window) begin
      // stream closes; flush a partial byte when open
      if (bytes_seen >= OPEN_COUNT) begin
        result.stream_end = 1'b1;
        if (bit_tally != 5'd0) begin
          gap = (bit_tally < BYTE_BITS_DONE) ? 5'(BYTE_BITS_DONE - bit_tally) : 5'd0;
          result.byte_valid = 1'b1;
          result.byte_value = gather_even(pulse_shift << gap);
        end
      end
      ps = '0;
      ph = HUNT_SILENCE;
      tl = '0;
      bs = '0;
    end else if (item.port_bits == PULSE_BITS) begin
      ps = {ps[14:0], 1'b1};
      unique case (ph)
        HUNT_SILENCE: begin
          if (ps == SYNC_SILENCE) ph = HUNT_SYNC;
        end
        HUNT_SYNC: begin
          if (ps == SYNC_MARK) begin
            ph = IN_DATA;
            result.byte_valid = 1'b1;
            result.byte_value = SYNC_BYTE;
            bs = count_up(bs);
            tl = '0;
            ps = '0;
          end
        end
        IN_DATA: tl = 5'(tl + 5'd1);
        default: ;
      endcase
      // long gap adds a zero bit
      if (item.elapsed_ticks >= one_bit_window) begin
        ps = {ps[14:0], 1'b0};
        unique case (ph)
          HUNT_SILENCE: begin
            if (ps == SYNC_SILENCE) ph = HUNT_SYNC;
          end
          HUNT_SYNC: begin
            if (ps == SYNC_MARK) ph = IN_DATA;
          end
          IN_DATA: tl = 5'(tl + 5'd1);
          default: ;
        endcase
      end
      if (tl > BYTE_BITS_FULL) begin
        result.byte_valid = 1'b1;
        result.byte_value = gather_even(ps);
        tl = 5'(tl - BYTE_BITS_FULL);
        ps = '0;
        bs = count_up(bs);
      end
    end
    pulse_shift_next = ps;
    sync_phase_next  = ph;
    bit_tally_next   = tl;
    bytes_seen_next  = bs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_shift <= '0;
      sync_phase  <= HUNT_SILENCE;
      bit_tally   <= '0;
      bytes_seen  <= '0;
    end else if (step) begin
      pulse_shift <= pulse_shift_next;
      sync_phase  <= sync_phase_next;
      bit_tally   <= bit_tally_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

endmodule

// ----- rtl/cassette_pulse_byte_decoder.sv -----
// top level of the cassette pulse byte decoder
`timescale 1ns / 1ps

// Decodes cassette port writes into bytes. Every accepted write gives exactly one
// result item, in order. One write can be accepted every clock cycle while results
// are taken; a write is held in the input register, decoded against the stream
// state in a single pass and lands in the result register. While a result waits, the
// input register can still take one write. The user must write the two window registers
// through the cfg port only while the block is idle; the block does not enforce this.

module cassette_pulse_byte_decoder
  import cpbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         write_valid,
  output logic         write_ready,
  input  write_item_t  write_item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  cfg_index_t   cfg_index,
  input  logic [23:0]  cfg_data
);

  write_item_t       in_q;
  logic              in_full;
  result_item_t      out_q;
  logic              out_full;
  logic [TICK_W-1:0] one_bit_window;
  logic [TICK_W-1:0] overrun_window;
  result_item_t      decoded;
  logic              out_free;
  logic              advance;

  assign out_free    = !out_full || result_ready;
  assign advance     = in_full && out_free;
  assign write_ready = !in_full || out_free;
  assign cfg_ready   = 1'b1;

  assign result_valid = out_full;
  assign result_item  = out_q;

  cpbd_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (in_q),
    .one_bit_window (one_bit_window),
    .overrun_window (overrun_window),
    .result         (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (write_valid && write_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (result_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_valid && write_ready) begin
      in_q <= write_item;
    end
    if (advance) begin
      out_q <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_bit_window <= ONE_BIT_WINDOW_RESET;
      overrun_window <= OVERRUN_WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ONE_BIT_WINDOW: one_bit_window <= cfg_data;
        CFG_OVERRUN_WINDOW: overrun_window <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
